[design/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;
    localparam int PRIO_W = 8;
    localparam int STATUS_W = 2;

    localparam int IN_BITS   = VAL_W + PRIO_W;
    localparam int IN_TDW    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = VAL_W;
    localparam int OUT_TDW   = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [VAL_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic {
        FUNC_ENQ = 1'b0,
        FUNC_DEQ = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_DEQUEUED = 2'd0,
        ST_ENQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic              enq;
        logic              deq;
        logic [VAL_W-1:0]  value;
        logic [PRIO_W-1:0] prio;
    } t_cell_ctl;

endpackage

[design/sorted_priority_queue_core.sv]
`timescale 1ns / 1ps
// Channel  | Dir | tdata (lowest bit first)               | tuser
// s_axis   | in  | item_value[31:0], item_priority[39:32] | func[0]
// m_axis   | out | out_value[31:0]                        | status[1:0]
//
// On every transfer, all cells compare against the new priority in parallel
// and shift by one slot, so one item can be accepted per cycle unless stalled.
// The result is held in an output register and is offered the cycle after its
// input transfer; a stalled output blocks input only while that register is
// full. Reset (synchronous, active low) clears the occupancy count and the
// output valid; cell contents need no reset.

module sorted_priority_queue_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [spq_pkg::IN_TDW-1:0]    i_s_tdata,  // item_value, item_priority
    input  logic                          i_s_tuser,  // func
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [spq_pkg::OUT_TDW-1:0]   o_m_tdata,  // out_value
    output logic [spq_pkg::STATUS_W-1:0]  o_m_tuser   // status
);

    localparam int D = spq_pkg::DEPTH;

    logic                       w_accept;
    spq_pkg::t_func             w_func;
    logic [spq_pkg::VAL_W-1:0]  w_item_value;
    logic [spq_pkg::PRIO_W-1:0] w_item_priority;
    logic                       w_full;
    logic                       w_empty;
    spq_pkg::t_cell_ctl         w_ctl;

    logic [spq_pkg::CNT_W-1:0]  r_count;
    logic [spq_pkg::CNT_W-1:0]  n_count;
    logic                       r_out_valid;
    logic [spq_pkg::VAL_W-1:0]  r_out_value;
    spq_pkg::t_status           r_out_status;
    logic [spq_pkg::VAL_W-1:0]  n_out_value;
    spq_pkg::t_status           n_out_status;

    logic [D-1:0]               w_keep;
    logic [spq_pkg::VAL_W-1:0]  w_value [D];
    logic [spq_pkg::PRIO_W-1:0] w_prio  [D];

    assign o_s_tready      = !r_out_valid || i_m_tready;
    assign w_accept        = i_s_tvalid && o_s_tready;
    assign w_func          = spq_pkg::t_func'(i_s_tuser);
    assign w_item_value    = i_s_tdata[spq_pkg::VAL_W-1:0];
    assign w_item_priority = i_s_tdata[spq_pkg::VAL_W+spq_pkg::PRIO_W-1:spq_pkg::VAL_W];
    assign w_full          = (r_count == spq_pkg::CNT_W'(D));
    assign w_empty         = (r_count == '0);

    assign w_ctl.enq   = w_accept && (w_func == spq_pkg::FUNC_ENQ) && !w_full;
    assign w_ctl.deq   = w_accept && (w_func == spq_pkg::FUNC_DEQ) && !w_empty;
    assign w_ctl.value = w_item_value;
    assign w_ctl.prio  = w_item_priority;

    for (genvar i = 0; i < D; i++) begin : g_cell
        logic                       w_left_keep;
        logic [spq_pkg::VAL_W-1:0]  w_left_value;
        logic [spq_pkg::PRIO_W-1:0] w_left_prio;
        logic [spq_pkg::VAL_W-1:0]  w_right_value;
        logic [spq_pkg::PRIO_W-1:0] w_right_prio;

        if (i == 0) begin : g_first
            assign w_left_keep  = 1'b1;
            assign w_left_value = w_item_value;
            assign w_left_prio  = w_item_priority;
        end else begin : g_inner
            assign w_left_keep  = w_keep[i-1];
            assign w_left_value = w_value[i-1];
            assign w_left_prio  = w_prio[i-1];
        end

        if (i == D - 1) begin : g_last
            assign w_right_value = w_value[i];
            assign w_right_prio  = w_prio[i];
        end else begin : g_body
            assign w_right_value = w_value[i+1];
            assign w_right_prio  = w_prio[i+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_valid      (spq_pkg::CNT_W'(i) < r_count),
            .i_left_keep  (w_left_keep),
            .i_left_value (w_left_value),
            .i_left_prio  (w_left_prio),
            .i_right_value(w_right_value),
            .i_right_prio (w_right_prio),
            .o_keep       (w_keep[i]),
            .o_value      (w_value[i]),
            .o_prio       (w_prio[i])
        );
    end

    always_comb begin
        n_count      = r_count;
        n_out_value  = '0;
        n_out_status = spq_pkg::ST_ENQUEUED;
        if (w_func == spq_pkg::FUNC_DEQ) begin
            if (w_empty) begin
                n_out_value  = spq_pkg::EMPTY_VALUE;
                n_out_status = spq_pkg::ST_EMPTY;
            end else begin
                n_out_value  = w_value[0];
                n_out_status = spq_pkg::ST_DEQUEUED;
                n_count      = r_count - spq_pkg::CNT_W'(1);
            end
        end else if (w_full) begin
            n_out_status = spq_pkg::ST_FULL;
        end else begin
            n_count = r_count + spq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = r_out_status;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::CNT_W'(D))
        else $error("Occupancy exceeds the queue depth.");

    a_empty_deq : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_func == spq_pkg::FUNC_DEQ && w_empty) |=>
            (r_count == '0 && r_out_status == spq_pkg::ST_EMPTY))
        else $error("A dequeue from an empty queue changed the state.");

    a_enq_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_func == spq_pkg::FUNC_ENQ && !w_full) |=>
            (r_count == $past(r_count) + spq_pkg::CNT_W'(1)))
        else $error("An accepted enqueue did not grow the queue by one.");

    a_full_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_func == spq_pkg::FUNC_ENQ && w_full) |=>
            (r_count == $past(r_count) && r_out_status == spq_pkg::ST_FULL))
        else $error("An enqueue into a full queue was not dropped.");

endmodule

[design/spq_cell.sv]
`timescale 1ns / 1ps

module spq_cell (
    input  logic                       i_clk,
    input  spq_pkg::t_cell_ctl         i_ctl,
    input  logic                       i_valid,
    input  logic                       i_left_keep,
    input  logic [spq_pkg::VAL_W-1:0]  i_left_value,
    input  logic [spq_pkg::PRIO_W-1:0] i_left_prio,
    input  logic [spq_pkg::VAL_W-1:0]  i_right_value,
    input  logic [spq_pkg::PRIO_W-1:0] i_right_prio,
    output logic                       o_keep,
    output logic [spq_pkg::VAL_W-1:0]  o_value,
    output logic [spq_pkg::PRIO_W-1:0] o_prio
);

    logic [spq_pkg::VAL_W-1:0]  r_value;
    logic [spq_pkg::PRIO_W-1:0] r_prio;
    logic [spq_pkg::VAL_W-1:0]  n_value;
    logic [spq_pkg::PRIO_W-1:0] n_prio;

    // A valid entry with a smaller number than the newcomer stays in place.
    assign o_keep  = i_valid && (r_prio < i_ctl.prio);
    assign o_value = r_value;
    assign o_prio  = r_prio;

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_ctl.enq && !o_keep) begin
            if (i_left_keep) begin
                n_value = i_ctl.value;
                n_prio  = i_ctl.prio;
            end else begin
                n_value = i_left_value;
                n_prio  = i_left_prio;
            end
        end else if (i_ctl.deq) begin
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

endmodule
